### rtl/stt_pkg.sv
`default_nettype none
package stt_pkg;

    localparam int PosBitsDefault = 16;
    localparam int KeywordChars   = 8;
    localparam int QueueDepth     = 4;
    localparam int LenMax         = 65535;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_NUMDOT,
        MODE_OP1,
        MODE_OP2
    } lex_mode_t;

    typedef enum logic [5:0] {
        K_EOF, K_IDENT, K_IF, K_ELSE, K_FUNCTION, K_FOR, K_BREAK, K_CONTINUE,
        K_INTEGER, K_DECIMAL, K_NEWLINE, K_LPAREN, K_RPAREN, K_LBRAC, K_RBRAC,
        K_LCURL, K_RCURL, K_DOT, K_COMMA, K_COLON, K_SEMI, K_QUESTION, K_PERCENT,
        K_PLUSPLUS, K_PLUSEQ, K_PLUS, K_MINUSMINUS, K_MINUSEQ, K_MINUS,
        K_STARSTAREQ, K_STARSTAR, K_STAREQ, K_STAR,
        K_SLASHSLASHEQ, K_SLASHSLASH, K_SLASHEQ, K_SLASH,
        K_LESSEQ, K_LESS, K_MOREEQ, K_MORE, K_BANGEQ, K_BANG, K_EQEQ, K_EQ,
        K_ANDAND, K_AND, K_BARBAR, K_BAR
    } kind_t;

    // Keyword spellings packed with the first character in the lowest byte.
    localparam logic [63:0] KwIf       = 64'h0000_0000_0000_6669;
    localparam logic [63:0] KwElse     = 64'h0000_0000_6573_6C65;
    localparam logic [63:0] KwFunction = 64'h6E6F_6974_636E_7566;
    localparam logic [63:0] KwFor      = 64'h0000_0000_0072_6F66;
    localparam logic [63:0] KwBreak    = 64'h0000_006B_6165_7262;
    localparam logic [63:0] KwContinue = 64'h6575_6E69_746E_6F63;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        inv;
    } tok_t;

    typedef struct packed {
        logic [1:0]     cnt;
        tok_t [2:0]     toks;
    } bundle_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h08;
    endfunction

    function automatic logic is_opc(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "<" ||
               c == ">" || c == "!" || c == "=" || c == "&" || c == "|";
    endfunction

    // Single punctuators; K_EOF means the byte is none of them.
    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            8'h0A:   k = K_NEWLINE;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRAC;
            "]":     k = K_RBRAC;
            "{":     k = K_LCURL;
            "}":     k = K_RCURL;
            ".":     k = K_DOT;
            ",":     k = K_COMMA;
            ":":     k = K_COLON;
            ";":     k = K_SEMI;
            "?":     k = K_QUESTION;
            "%":     k = K_PERCENT;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic kind_t op_single(input logic [7:0] a);
        kind_t k;
        unique case (a)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "<":     k = K_LESS;
            ">":     k = K_MORE;
            "!":     k = K_BANG;
            "=":     k = K_EQ;
            "&":     k = K_AND;
            default: k = K_BAR;
        endcase
        return k;
    endfunction

    // Two-character operator, K_EOF when the pair forms none.
    function automatic kind_t op_pair(input logic [7:0] a, input logic [7:0] c);
        kind_t k;
        k = K_EOF;
        if (c == "=") begin
            unique case (a)
                "+":     k = K_PLUSEQ;
                "-":     k = K_MINUSEQ;
                "*":     k = K_STAREQ;
                "/":     k = K_SLASHEQ;
                "<":     k = K_LESSEQ;
                ">":     k = K_MOREEQ;
                "!":     k = K_BANGEQ;
                "=":     k = K_EQEQ;
                default: k = K_EOF;
            endcase
        end else if (a == c) begin
            unique case (a)
                "+":     k = K_PLUSPLUS;
                "-":     k = K_MINUSMINUS;
                "&":     k = K_ANDAND;
                "|":     k = K_BARBAR;
                default: k = K_EOF;
            endcase
        end
        return k;
    endfunction

    function automatic kind_t ident_kind(input logic [63:0] buf_w, input logic [15:0] len);
        kind_t k;
        k = K_IDENT;
        if (len == 16'd2 && buf_w == KwIf)            k = K_IF;
        else if (len == 16'd4 && buf_w == KwElse)     k = K_ELSE;
        else if (len == 16'd8 && buf_w == KwFunction) k = K_FUNCTION;
        else if (len == 16'd3 && buf_w == KwFor)      k = K_FOR;
        else if (len == 16'd5 && buf_w == KwBreak)    k = K_BREAK;
        else if (len == 16'd8 && buf_w == KwContinue) k = K_CONTINUE;
        return k;
    endfunction

    function automatic logic [15:0] len_add(input logic [15:0] a, input logic [1:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {15'd0, b};
        return s[16] ? 16'(LenMax) : s[15:0];
    endfunction

endpackage
`default_nettype wire

### rtl/stt_front.sv
`default_nettype none
module stt_front import stt_pkg::*; #(
    parameter int POS_BITS = PosBitsDefault
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] char_byte,
    input  wire logic       end_marker,
    output bundle_t         bundle,
    output logic            has_tokens
);

    lex_mode_t             mode_reg, mode_next;
    logic [7:0]            pend_reg, pend_next;
    logic [POS_BITS-1:0]   start_reg, start_next;
    logic [15:0]           len_reg, len_next;
    logic [63:0]           kwbuf_reg, kwbuf_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic                  dec_reg, dec_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            kwbuf_reg <= '0;
            pos_reg   <= '0;
            dec_reg   <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kwbuf_reg <= kwbuf_next;
            pos_reg   <= pos_next;
            dec_reg   <= dec_next;
        end
    end

    logic [POS_BITS-1:0] pos_m1;
    logic [15:0]         p16;
    logic                do_flush;
    logic                do_begin;
    logic [1:0]          n;
    kind_t               pk;

    assign pos_m1 = pos_reg - POS_BITS'(1);
    assign p16    = 16'(pos_reg);

    always_comb begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kwbuf_next = kwbuf_reg;
        pos_next   = pos_reg + POS_BITS'(1);
        dec_next   = dec_reg;
        do_flush   = 1'b0;
        do_begin   = 1'b0;
        n          = 2'd0;
        pk         = op_pair(pend_reg, char_byte);
        bundle     = '0;

        if (end_marker) begin
            do_flush = 1'b1;
        end else begin
            unique case (mode_reg)
                MODE_IDENT: begin
                    if (is_alpha(char_byte) || is_digit(char_byte) || char_byte == "_") begin
                        for (int i = 0; i < KeywordChars; i++) begin
                            if (len_reg == 16'(i)) kwbuf_next[8*i +: 8] = char_byte;
                        end
                        len_next = len_add(len_reg, 2'd1);
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_digit(char_byte)) begin
                        len_next = len_add(len_reg, 2'd1);
                    end else if (char_byte == "." && !dec_reg) begin
                        mode_next = MODE_NUMDOT;
                        pend_next = char_byte;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                MODE_NUMDOT: begin
                    if (is_digit(char_byte)) begin
                        dec_next  = 1'b1;
                        len_next  = len_add(len_reg, 2'd2);
                        mode_next = MODE_NUM;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                MODE_OP1: begin
                    if ((pend_reg == "*" || pend_reg == "/") && char_byte == pend_reg) begin
                        mode_next = MODE_OP2;
                    end else if (pk != K_EOF) begin
                        bundle.toks[0] = '{kind: pk, start: 16'(start_reg), len: 16'd2,
                                           inv: 1'b0};
                        n         = 2'd1;
                        mode_next = MODE_IDLE;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                MODE_OP2: begin
                    if (char_byte == "=") begin
                        bundle.toks[0] = '{kind: (pend_reg == "*") ? K_STARSTAREQ
                                                                   : K_SLASHSLASHEQ,
                                           start: 16'(start_reg), len: 16'd3, inv: 1'b0};
                        n         = 2'd1;
                        mode_next = MODE_IDLE;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                default: begin
                    do_begin = 1'b1;
                end
            endcase
        end

        if (do_flush) begin
            unique case (mode_reg)
                MODE_IDENT: begin
                    bundle.toks[n] = '{kind: ident_kind(kwbuf_reg, len_reg),
                                       start: 16'(start_reg), len: len_reg, inv: 1'b0};
                    n = n + 2'd1;
                end
                MODE_NUM: begin
                    bundle.toks[n] = '{kind: dec_reg ? K_DECIMAL : K_INTEGER,
                                       start: 16'(start_reg), len: len_reg, inv: 1'b0};
                    n = n + 2'd1;
                end
                MODE_NUMDOT: begin
                    bundle.toks[n] = '{kind: K_INTEGER, start: 16'(start_reg),
                                       len: len_reg, inv: 1'b0};
                    n = n + 2'd1;
                    bundle.toks[n] = '{kind: K_DOT, start: 16'(pos_m1), len: 16'd1,
                                       inv: 1'b0};
                    n = n + 2'd1;
                end
                MODE_OP1: begin
                    bundle.toks[n] = '{kind: op_single(pend_reg), start: 16'(start_reg),
                                       len: 16'd1, inv: 1'b0};
                    n = n + 2'd1;
                end
                MODE_OP2: begin
                    bundle.toks[n] = '{kind: (pend_reg == "*") ? K_STARSTAR : K_SLASHSLASH,
                                       start: 16'(start_reg), len: 16'd2, inv: 1'b0};
                    n = n + 2'd1;
                end
                default: ;
            endcase
            mode_next = MODE_IDLE;
        end

        if (do_begin) begin
            mode_next = MODE_IDLE;
            if (is_space(char_byte)) begin
                mode_next = MODE_IDLE;
            end else if (is_alpha(char_byte) || char_byte == "_") begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                len_next   = 16'd1;
                kwbuf_next = {56'd0, char_byte};
            end else if (is_digit(char_byte)) begin
                mode_next  = MODE_NUM;
                start_next = pos_reg;
                len_next   = 16'd1;
                dec_next   = 1'b0;
            end else if (single_kind(char_byte) != K_EOF) begin
                bundle.toks[n] = '{kind: single_kind(char_byte), start: p16, len: 16'd1,
                                   inv: 1'b0};
                n = n + 2'd1;
            end else if (is_opc(char_byte)) begin
                mode_next  = MODE_OP1;
                pend_next  = char_byte;
                start_next = pos_reg;
            end else begin
                bundle.toks[n] = '{kind: K_EOF, start: p16, len: 16'd1, inv: 1'b1};
                n = n + 2'd1;
            end
        end

        if (end_marker) begin
            bundle.toks[n] = '{kind: K_EOF, start: p16, len: 16'd1, inv: 1'b0};
            n          = n + 2'd1;
            mode_next  = MODE_IDLE;
            pend_next  = '0;
            start_next = '0;
            len_next   = '0;
            kwbuf_next = '0;
            pos_next   = '0;
            dec_next   = 1'b0;
        end

        bundle.cnt = n;
        has_tokens = (n != 2'd0);
    end

endmodule
`default_nettype wire

### rtl/stt_queue.sv
`default_nettype none
module stt_queue import stt_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire bundle_t push_data,
    output logic         full,
    input  wire logic    pop,
    output logic         not_empty,
    output bundle_t      head
);

    localparam int PtrBits = $clog2(QueueDepth);

    bundle_t              mem [QueueDepth];
    logic [PtrBits-1:0]   wr_reg, rd_reg;
    logic [PtrBits:0]     count_reg;

    assign full      = (count_reg == (PtrBits+1)'(QueueDepth));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + PtrBits'(1);
            if (pop)  rd_reg <= rd_reg + PtrBits'(1);
            count_reg <= count_reg + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
        end
    end

endmodule
`default_nettype wire

### rtl/stt_back.sv
`default_nettype none
module stt_back import stt_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    q_valid,
    input  wire bundle_t q_head,
    output logic         q_pop,
    output logic         m_valid,
    input  wire logic    m_ready,
    output tok_t         m_tok,
    output logic         m_last
);

    logic [1:0] sub_reg, sub_next;
    logic       valid_reg, valid_next;
    tok_t       tok_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;

    assign load    = q_valid && (!valid_reg || m_ready);
    assign is_last = (sub_reg == q_head.cnt - 2'd1);
    assign q_pop   = load && is_last;

    always_comb begin
        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            sub_next   = is_last ? 2'd0 : sub_reg + 2'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg  <= q_head.toks[sub_reg];
            last_reg <= is_last;
        end
    end

    assign m_valid = valid_reg;
    assign m_tok   = tok_reg;
    assign m_last  = last_reg;

endmodule
`default_nettype wire

### rtl/source_text_tokenizer.sv
// Streaming tokenizer: one source byte per beat goes in on the s_ side and tokens
// (kind, start offset, length) come out on the m_ side, with tlast on the last token
// that a byte caused. A byte is taken every cycle while the four-entry token queue
// between the lexer and the output serializer has room; the serializer sends the
// tokens of a byte one at a time, so input sustains one byte per cycle on ordinary
// text while m_tready holds, and drops where a byte yields more than one token.
// Unknown bytes come out as kind 0 with tuser set; the end marker flushes and
// emits Eof, then restarts offsets at zero.
`default_nettype none
module source_text_tokenizer import stt_pkg::*; #(
    parameter int POS_BITS = PosBitsDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_byte
    input  wire logic        s_tuser,   // end_marker
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // token_kind, start_offset, token_length, zero pad
    output logic             m_tuser,   // invalid_char
    output logic             m_tlast    // last_of_run
);

    logic    accept;
    bundle_t bundle;
    logic    has_tokens;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    bundle_t q_head;
    tok_t    tok;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    stt_front #(.POS_BITS(POS_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .char_byte  (s_tdata),
        .end_marker (s_tuser),
        .bundle     (bundle),
        .has_tokens (has_tokens)
    );

    stt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && has_tokens),
        .push_data (bundle),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    stt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_tok   (tok),
        .m_last  (m_tlast)
    );

    assign m_tdata = {2'b00, tok.len, tok.start, tok.kind};
    assign m_tuser = tok.inv;

endmodule
`default_nettype wire

### tb/stt_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module stt_checker import stt_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // char_byte
    input  wire logic        s_tuser,   // end_marker
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // token_kind, start_offset, token_length, zero pad
    input  wire logic        m_tuser,   // invalid_char
    input  wire logic        m_tlast,   // last_of_run
    output int               fail_count,
    output int               tokens_pending,
    output int               tokens_seen
);

    typedef struct {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        inv;
        logic        last;
    } token_t;

    token_t expected_tokens[$];
    token_t step_tokens[$];

    lex_mode_t   mode;
    logic [7:0]  held_op;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [63:0] word_buf;
    logic [15:0] position;
    logic        has_fraction;

    assign tokens_pending = expected_tokens.size();

    function automatic logic letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [63:0] spell(input string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len(); i++) w[8*i +: 8] = s[i];
        return w;
    endfunction

    function automatic kind_t word_kind(input logic [63:0] w, input logic [15:0] n);
        string words[6];
        kind_t kinds[6];
        words = '{"if", "else", "function", "for", "break", "continue"};
        kinds = '{K_IF, K_ELSE, K_FUNCTION, K_FOR, K_BREAK, K_CONTINUE};
        for (int i = 0; i < 6; i++)
            if (n == 16'(words[i].len()) && w == spell(words[i])) return kinds[i];
        return K_IDENT;
    endfunction

    function automatic kind_t lone_op(input logic [7:0] a);
        case (a)
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_STAR;
            "/": return K_SLASH;
            "<": return K_LESS;
            ">": return K_MORE;
            "!": return K_BANG;
            "=": return K_EQ;
            "&": return K_AND;
            default: return K_BAR;
        endcase
    endfunction

    // Returns K_EOF when the two bytes do not form an operator.
    function automatic kind_t paired_op(input logic [7:0] a, input logic [7:0] c);
        if (c == "=") begin
            case (a)
                "+": return K_PLUSEQ;
                "-": return K_MINUSEQ;
                "*": return K_STAREQ;
                "/": return K_SLASHEQ;
                "<": return K_LESSEQ;
                ">": return K_MOREEQ;
                "!": return K_BANGEQ;
                "=": return K_EQEQ;
                default: return K_EOF;
            endcase
        end
        if (a == c) begin
            case (a)
                "+": return K_PLUSPLUS;
                "-": return K_MINUSMINUS;
                "&": return K_ANDAND;
                "|": return K_BARBAR;
                default: return K_EOF;
            endcase
        end
        return K_EOF;
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] a, input int b);
        int s;
        s = int'(a) + b;
        return s > 65535 ? 16'hFFFF : 16'(s);
    endfunction

    task automatic push_token(input kind_t k, input logic [15:0] st, input logic [15:0] n,
                              input logic inv);
        token_t t;
        t = '{kind: k, start: st, len: n, inv: inv, last: 1'b0};
        if (step_tokens.size() < 4) step_tokens.push_back(t);
    endtask

    task automatic close_token(input logic [15:0] p);
        case (mode)
            MODE_IDENT:  push_token(word_kind(word_buf, tok_len), tok_start, tok_len, 0);
            MODE_NUM:    push_token(has_fraction ? K_DECIMAL : K_INTEGER, tok_start, tok_len, 0);
            MODE_NUMDOT: begin
                push_token(K_INTEGER, tok_start, tok_len, 0);
                push_token(K_DOT, p - 16'd1, 16'd1, 0);
            end
            MODE_OP1:    push_token(lone_op(held_op), tok_start, 16'd1, 0);
            MODE_OP2:    push_token(held_op == "*" ? K_STARSTAR : K_SLASHSLASH, tok_start,
                                    16'd2, 0);
            default: ;
        endcase
        mode = MODE_IDLE;
    endtask

    task automatic open_token(input logic [7:0] c, input logic [15:0] p);
        string singles;
        singles = "\n()[]{}.,:;?%";
        mode = MODE_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h08) return;
        if (letter(c) || c == "_") begin
            mode = MODE_IDENT;
            tok_start = p;
            tok_len = 16'd1;
            word_buf = {56'd0, c};
            return;
        end
        if (digit(c)) begin
            mode = MODE_NUM;
            tok_start = p;
            tok_len = 16'd1;
            has_fraction = 1'b0;
            return;
        end
        for (int i = 0; i < singles.len(); i++)
            if (singles[i] == c) begin
                push_token(kind_t'(int'(K_NEWLINE) + i), p, 16'd1, 0);
                return;
            end
        if (c inside {"+", "-", "*", "/", "<", ">", "!", "=", "&", "|"}) begin
            mode = MODE_OP1;
            held_op = c;
            tok_start = p;
            return;
        end
        push_token(K_EOF, p, 16'd1, 1'b1);
    endtask

    task automatic clear_state();
        mode = MODE_IDLE;
        held_op = '0;
        tok_start = '0;
        tok_len = '0;
        word_buf = '0;
        position = '0;
        has_fraction = 1'b0;
    endtask

    // Works out the tokens that one input beat completes and queues them.
    task automatic lex_byte(input logic [7:0] c, input logic end_mark);
        logic [15:0] p;
        kind_t k;
        p = position;
        step_tokens.delete();
        if (end_mark) begin
            close_token(p);
            push_token(K_EOF, p, 16'd1, 0);
            clear_state();
        end else begin
            case (mode)
                MODE_IDENT:
                    if (letter(c) || digit(c) || c == "_") begin
                        if (tok_len < 16'd8) word_buf[8*tok_len[2:0] +: 8] = c;
                        tok_len = sat_add(tok_len, 1);
                    end else begin
                        close_token(p);
                        open_token(c, p);
                    end
                MODE_NUM:
                    if (digit(c)) tok_len = sat_add(tok_len, 1);
                    else if (c == "." && !has_fraction) mode = MODE_NUMDOT;
                    else begin
                        close_token(p);
                        open_token(c, p);
                    end
                MODE_NUMDOT:
                    if (digit(c)) begin
                        has_fraction = 1'b1;
                        tok_len = sat_add(tok_len, 2);
                        mode = MODE_NUM;
                    end else begin
                        close_token(p);
                        open_token(c, p);
                    end
                MODE_OP1: begin
                    k = paired_op(held_op, c);
                    if ((held_op == "*" || held_op == "/") && c == held_op) mode = MODE_OP2;
                    else if (k != K_EOF) begin
                        push_token(k, tok_start, 16'd2, 0);
                        mode = MODE_IDLE;
                    end else begin
                        close_token(p);
                        open_token(c, p);
                    end
                end
                MODE_OP2:
                    if (c == "=") begin
                        push_token(held_op == "*" ? K_STARSTAREQ : K_SLASHSLASHEQ, tok_start,
                                   16'd3, 0);
                        mode = MODE_IDLE;
                    end else begin
                        close_token(p);
                        open_token(c, p);
                    end
                default: open_token(c, p);
            endcase
            position = p + 16'd1;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endtask

    task automatic report(input string what, input int got, input int want);
        fail_count++;
        $display("[%0t] token %0d: %s got %0d expected %0d", $realtime, tokens_seen, what,
                 got, want);
    endtask

    initial begin
        fail_count = 0;
        tokens_seen = 0;
        clear_state();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
        end else begin
            if (s_tvalid && s_tready) lex_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                token_t t;
                if (expected_tokens.size() == 0) begin
                    report("unexpected token, kind", int'(m_tdata[5:0]), -1);
                end else begin
                    t = expected_tokens.pop_front();
                    if (m_tdata[5:0] != t.kind) report("kind", m_tdata[5:0], t.kind);
                    if (m_tdata[21:6] != t.start) report("start", m_tdata[21:6], t.start);
                    if (m_tdata[37:22] != t.len) report("length", m_tdata[37:22], t.len);
                    if (m_tdata[39:38] != 2'b00) report("pad", m_tdata[39:38], 0);
                    if (m_tuser != t.inv) report("invalid flag", m_tuser, t.inv);
                    if (m_tlast != t.last) report("last flag", m_tlast, t.last);
                end
                tokens_seen++;
            end
        end
    end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import stt_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // char_byte
    logic        s_tuser = 1'b0; // end_marker
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // token_kind, start_offset, token_length, zero pad
    logic        m_tuser;        // invalid_char
    logic        m_tlast;        // last_of_run

    int fail_count, tokens_pending, tokens_seen;
    int bytes_sent = 0;
    int sources_ended = 0;
    bit no_gaps = 1'b0;
    bit hold_sink = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    source_text_tokenizer u_top (.*);

    stt_checker u_check (.*);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic end_mark);
        bit taken;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= end_mark;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end
        bytes_sent++;
        if (end_mark) sources_ended++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom);
            s_tuser <= 1'($urandom);
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // Mostly well-formed source fragments, with some raw noise bytes.
    function automatic string random_fragment();
        string frags[] = '{"if", "else", "function", "for", "break", "continue", "functio",
                           "functions", "fo", "_x9", "Zq", "42", "3.14", "7.", "1.2.3", "0",
                           "**=", "**", "*=", "*", "//=", "//", "/=", "/", "++", "+=", "+",
                           "--", "-=", "-", "<=", "<", ">=", ">", "!=", "!", "==", "=",
                           "&&", "&", "||", "|", "(", ")", "[", "]", "{", "}", ".", ",",
                           ":", ";", "?", "%", "\n", " ", "\t", "\r"};
        string s;
        int n;
        s = frags[$urandom_range(0, frags.size() - 1)];
        if ($urandom_range(0, 3) == 0) begin
            s = "";
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 8) == 0 ?
                                              $urandom_range(128, 255) : $urandom_range(33, 126)))};
        end
        if ($urandom_range(0, 2) == 0) s = {s, " "};
        return s;
    endfunction

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_sink) m_tready <= 1'b0;
        else if (no_gaps) m_tready <= 1'b1;
        else if (!m_tready) m_tready <= ($urandom_range(0, 99) < 40);
        else m_tready <= ($urandom_range(0, 99) >= 20);
    end

    // Long receiver hold-off so the token queue fills and the input stalls.
    initial begin
        wait (bytes_sent >= 120);
        @(posedge aclk);
        hold_sink <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_sink <= 1'b0;
    end

    initial begin
        #20_000_000;
        $display("source_text_tokenizer: mismatch");
        $finish;
    end

    initial begin
        int wait_cycles;
        @(posedge aclk iff aresetn);
        @(posedge aclk);
        // Directed: keywords, three-character operators, decimals, dot cases, noise.
        send_text("if else**=//=.5 3.4.5 7.\n");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(8'h41, 1'b1);
        while (bytes_sent < 300) begin
            if ($urandom_range(0, 39) == 0) send_byte(8'($urandom), 1'b1);
            else send_text(random_fragment());
        end
        send_byte(8'h00, 1'b1);
        // A short source sent back to back with the receiver always ready.
        no_gaps = 1'b1;
        send_text("for x1=2.5;x1**=3 ");
        send_byte(8'h00, 1'b1);
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (tokens_pending != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (20) @(posedge aclk);
        $display("Sent %0d bytes over %0d sources; %0d tokens checked.", bytes_sent,
                 sources_ended, tokens_seen);
        if (fail_count == 0 && tokens_pending == 0) begin
            $display("source_text_tokenizer: match");
        end else begin
            $display("%0d mismatches, %0d tokens never seen.", fail_count, tokens_pending);
            $display("source_text_tokenizer: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
